### hdl/ptor_pkg.sv
`default_nettype none

package ptor_pkg;

   // default table size
   localparam int TABLE_DEPTH_DEF = 64;

   // reset value of the idle limit
   localparam logic [31:0] AWAY_RESET = 32'd120000;

   // request modes
   localparam logic [1:0] MODE_SIGHT = 2'd0;
   localparam logic [1:0] MODE_SWEEP = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_UPDATED    = 3'd0;
   localparam logic [2:0] ST_APPENDED   = 3'd1;
   localparam logic [2:0] ST_REUSED     = 3'd2;
   localparam logic [2:0] ST_REPLACED   = 3'd3;
   localparam logic [2:0] ST_MARKED     = 3'd4;
   localparam logic [2:0] ST_NONE_IDLE  = 3'd5;
   localparam logic [2:0] ST_READ       = 3'd6;
   localparam logic [2:0] ST_READ_EMPTY = 3'd7;

   typedef struct packed {
      logic [1:0]        mode;
      logic [63:0]       peer_key;
      logic signed [7:0] signal_dbm;
      logic [15:0]       session_count;
      logic [15:0]       total_count;
      logic [31:0]       now_ms;
      logic [5:0]        read_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [5:0]        slot;
      logic [6:0]        peer_count;
      logic [15:0]       last_total;
      logic [15:0]       last_session;
      logic [63:0]       entry_key;
      logic signed [7:0] entry_signal;
      logic              entry_gone;
      logic [31:0]       entry_last_seen;
      logic [15:0]       entry_total;
      logic [15:0]       entry_session;
   } rsp_type;

   // one stored peer
   typedef struct packed {
      logic [63:0]       key;
      logic [31:0]       seen;
      logic              gone;
      logic signed [7:0] signal;
      logic [15:0]       total;
      logic [15:0]       session;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_more;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

### hdl/ptor_controller.sv
`default_nettype none

module ptor_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ptor_pkg::sts_type sts,
   output ptor_pkg::cmd_type      cmd
);

   ptor_pkg::state_type state_ff;
   ptor_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptor_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptor_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ptor_pkg::S_SCAN;
            end
         end
         ptor_pkg::S_SCAN: begin
            if (!sts.scan_more) begin
               state_in = ptor_pkg::S_COMMIT;
            end
         end
         ptor_pkg::S_COMMIT: begin
            if (sts.rsp_free) begin
               state_in = ptor_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptor_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd.load   = 1'b0;
      cmd.issue  = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ptor_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ptor_pkg::S_SCAN: begin
            cmd.issue = sts.scan_more;
         end
         ptor_pkg::S_COMMIT: begin
            cmd.commit = sts.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/ptor_datapath.sv
`default_nettype none

module ptor_datapath #(
   parameter int TABLE_DEPTH = ptor_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ptor_pkg::cmd_type cmd,
   output ptor_pkg::sts_type      sts,
   input  wire ptor_pkg::req_type req_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output ptor_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   input  wire logic [31:0]       csr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   ptor_pkg::entry_type mem [TABLE_DEPTH];

   ptor_pkg::req_type   req_ff;
   ptor_pkg::entry_type rd_data_ff;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [CNT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]    lim_ff;
   logic                pend_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic                match_found_ff;
   logic [IDX_W-1:0]    match_idx_ff;
   logic                gone_found_ff;
   logic [IDX_W-1:0]    gone_idx_ff;
   logic [31:0]         best_seen_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic                idle_found_ff;
   logic [IDX_W-1:0]    idle_idx_ff;
   ptor_pkg::entry_type idle_ent_ff;
   logic [15:0]         latest_total_ff, latest_total_in;
   logic [15:0]         latest_session_ff, latest_session_in;
   logic [31:0]         away_ff;
   logic                rsp_vld_ff;
   ptor_pkg::rsp_type   rsp_ff, rsp_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   ptor_pkg::entry_type wr_ent;
   ptor_pkg::entry_type new_ent;
   logic [IDX_W-1:0]    rd_addr;
   logic [31:0]         age;

   // read slot against the fill count, widened so any depth compares right
   logic [IDX_W+6:0]    in_slot_w, cur_slot_w, occ_w;
   logic                in_hit, cur_hit;
   logic [IDX_W+5:0]    slot_w;
   logic [CNT_W+6:0]    cnt_w;

   assign occ_w      = (IDX_W + 7)'(occ_ff);
   assign in_slot_w  = (IDX_W + 7)'(req_data.read_slot);
   assign cur_slot_w = (IDX_W + 7)'(req_ff.read_slot);
   assign in_hit     = in_slot_w < occ_w;
   assign cur_hit    = cur_slot_w < occ_w;

   assign sts.scan_more = ptr_ff < lim_ff;
   assign sts.rsp_free  = !rsp_vld_ff || !rsp_stall;

   assign rd_addr = (req_ff.mode == ptor_pkg::MODE_READ) ? cur_slot_w[IDX_W-1:0]
                                                         : ptr_ff[IDX_W-1:0];
   assign age     = req_ff.now_ms - rd_data_ff.seen;

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.issue;
      end
      if (cmd.issue) begin
         pend_idx_ff <= ptr_ff[IDX_W-1:0];
         ptr_ff      <= ptr_ff + 1'b1;
      end
      if (cmd.load) begin
         req_ff         <= req_data;
         ptr_ff         <= '0;
         match_found_ff <= 1'b0;
         gone_found_ff  <= 1'b0;
         idle_found_ff  <= 1'b0;
         case (req_data.mode)
            ptor_pkg::MODE_SIGHT, ptor_pkg::MODE_SWEEP: begin
               lim_ff <= occ_ff;
            end
            ptor_pkg::MODE_READ: begin
               lim_ff <= in_hit ? CNT_W'(1) : '0;
            end
            default: begin
               lim_ff <= '0;
            end
         endcase
      end else if (pend_ff) begin
         if (!match_found_ff && rd_data_ff.key == req_ff.peer_key) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= pend_idx_ff;
         end
         if (!gone_found_ff && rd_data_ff.gone) begin
            gone_found_ff <= 1'b1;
            gone_idx_ff   <= pend_idx_ff;
         end
         if (pend_idx_ff == '0 || rd_data_ff.seen < best_seen_ff) begin
            best_seen_ff <= rd_data_ff.seen;
            best_idx_ff  <= pend_idx_ff;
         end
         if (!idle_found_ff && age > away_ff) begin
            idle_found_ff <= 1'b1;
            idle_idx_ff   <= pend_idx_ff;
            idle_ent_ff   <= rd_data_ff;
         end
      end
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_ent;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      new_ent.key     = req_ff.peer_key;
      new_ent.seen    = req_ff.now_ms;
      new_ent.gone    = 1'b0;
      new_ent.signal  = req_ff.signal_dbm;
      new_ent.total   = req_ff.total_count;
      new_ent.session = req_ff.session_count;
   end

   // commit decision
   always_comb begin
      wr_en             = 1'b0;
      wr_idx            = '0;
      wr_ent            = new_ent;
      occ_in            = occ_ff;
      latest_total_in   = latest_total_ff;
      latest_session_in = latest_session_ff;
      rsp_in            = '0;
      rsp_in.status     = ptor_pkg::ST_NONE_IDLE;
      case (req_ff.mode)
         ptor_pkg::MODE_SIGHT: begin
            wr_en             = 1'b1;
            latest_total_in   = req_ff.total_count;
            latest_session_in = req_ff.session_count;
            if (match_found_ff) begin
               wr_idx        = match_idx_ff;
               rsp_in.status = ptor_pkg::ST_UPDATED;
            end else if (occ_ff != DEPTH_CNT) begin
               wr_idx        = occ_ff[IDX_W-1:0];
               occ_in        = occ_ff + 1'b1;
               rsp_in.status = ptor_pkg::ST_APPENDED;
            end else if (gone_found_ff) begin
               wr_idx        = gone_idx_ff;
               rsp_in.status = ptor_pkg::ST_REUSED;
            end else begin
               wr_idx        = best_idx_ff;
               rsp_in.status = ptor_pkg::ST_REPLACED;
            end
         end
         ptor_pkg::MODE_SWEEP: begin
            if (idle_found_ff) begin
               wr_en         = 1'b1;
               wr_idx        = idle_idx_ff;
               wr_ent        = idle_ent_ff;
               wr_ent.gone   = 1'b1;
               rsp_in.status = ptor_pkg::ST_MARKED;
            end
         end
         ptor_pkg::MODE_READ: begin
            if (cur_hit) begin
               rsp_in.status          = ptor_pkg::ST_READ;
               rsp_in.entry_key       = rd_data_ff.key;
               rsp_in.entry_signal    = rd_data_ff.signal;
               rsp_in.entry_gone      = rd_data_ff.gone;
               rsp_in.entry_last_seen = rd_data_ff.seen;
               rsp_in.entry_total     = rd_data_ff.total;
               rsp_in.entry_session   = rd_data_ff.session;
            end else begin
               rsp_in.status = ptor_pkg::ST_READ_EMPTY;
            end
         end
         default: begin
            rsp_in.status = ptor_pkg::ST_NONE_IDLE;
         end
      endcase
      if (req_ff.mode == ptor_pkg::MODE_READ) begin
         slot_w = (IDX_W + 6)'(req_ff.read_slot);
      end else if (wr_en) begin
         slot_w = (IDX_W + 6)'(wr_idx);
      end else begin
         slot_w = '0;
      end
      cnt_w               = (CNT_W + 7)'(occ_in);
      rsp_in.slot         = slot_w[5:0];
      rsp_in.peer_count   = cnt_w[6:0];
      rsp_in.last_total   = latest_total_in;
      rsp_in.last_session = latest_session_in;
      if (!cmd.commit) begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff            <= '0;
         latest_total_ff   <= '0;
         latest_session_ff <= '0;
         away_ff           <= ptor_pkg::AWAY_RESET;
         rsp_vld_ff        <= 1'b0;
      end else begin
         if (csr_valid) begin
            away_ff <= csr_data;
         end
         if (cmd.commit) begin
            occ_ff            <= occ_in;
            latest_total_ff   <= latest_total_in;
            latest_session_ff <= latest_session_in;
            rsp_vld_ff        <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### hdl/peer_table_oldest_replace.sv
`default_nettype none

// Peer table with oldest-entry replacement. Holds up to TABLE_DEPTH peers keyed
// by a 64-bit identity, one request transfer in and one result transfer out per
// item. A sighting refreshes the matching entry, else appends, else reuses the
// first gone entry, else replaces the entry with the smallest last-seen stamp.
// A sweep marks the first occupied entry idle beyond the csr limit as gone; a
// read returns one entry. Items are handled one at a time: a sighting or sweep
// scans every occupied entry before its result is offered, a read hit reads
// its one entry, and a read miss or an unused mode reads none. The scan walks
// the entry memory's single read port one entry per cycle. Stored entries are
// not cleared after reset; only entries below the fill count are ever read.
// The csr register may be written only while idle.

module peer_table_oldest_replace #(
   parameter int TABLE_DEPTH = ptor_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ptor_pkg::req_type req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ptor_pkg::rsp_type      rsp_data,
   // idle limit register write
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);

   ptor_pkg::cmd_type cmd;
   ptor_pkg::sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: accept, scan the table, commit and hand over the result
   ptor_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entry memory, scan registers, fill count and result register
   ptor_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

### hdl/ptor_checker.sv
`default_nettype none

module ptor_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ptor_pkg::rsp_type rsp_data
);

   // a held result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // nothing is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // entry fields only carry data on a read hit
   a_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ptor_pkg::ST_READ |->
         rsp_data.entry_key == '0 && rsp_data.entry_last_seen == '0 &&
         rsp_data.entry_total == '0 && rsp_data.entry_session == '0 &&
         !rsp_data.entry_gone && rsp_data.entry_signal == '0)
      else $error("entry fields set outside a read hit");

   // nothing touched means slot zero
   a_none_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ptor_pkg::ST_NONE_IDLE |-> rsp_data.slot == '0)
      else $error("slot set on a no-op result");

endmodule

bind peer_table_oldest_replace ptor_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
